[rtl/sefcrc_pkg.sv]
package sefcrc_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] crc_value;
    logic [7:0]  frame_count;
    logic        truncated;
  } out_t;

  // Result descriptor handed from the frame core to the output stage.
  typedef struct packed {
    logic        vld;    // item produces at least one beat
    logic        three;  // write-mode close: byte, CRC low, CRC high
    logic        lst;    // out_last of a single-beat result
    logic [7:0]  byte_v;
    logic [15:0] crc;
    logic [7:0]  cnt;
    logic        trunc;
  } bnd_t;

endpackage

[rtl/sefcrc_core.sv]
module sefcrc_core import sefcrc_pkg::*; #(
  parameter logic [7:0] Limit = 8'd255
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  in_t  in_data,
  output bnd_t bnd
);

  logic [15:0] crc_r,  crc_nxt;
  logic [7:0]  idx_r,  idx_nxt;
  logic [7:0]  len_r,  len_nxt;
  logic [7:0]  dly0_r, dly0_nxt;
  logic [7:0]  dly1_r, dly1_nxt;

  // Reflected CRC-16, eight bits per byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [15:0] flip16(input logic [15:0] c);
    logic [15:0] v;
    for (int k = 0; k < 16; k++) begin
      v[k] = c[15-k];
    end
    return v;
  endfunction

  logic        act;
  logic [7:0]  used;

  always_comb begin
    crc_nxt  = crc_r;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    dly0_nxt = dly0_r;
    dly1_nxt = dly1_r;
    act      = idx_r < Limit;
    bnd      = '0;
    used     = '0;

    if (in_data.op == OP_WRITE) begin
      if (idx_r != 8'd0) crc_nxt = crc_feed(crc_r, in_data.data_byte);
      if (act) idx_nxt = idx_r + 8'd1;
      bnd.vld    = 1'b1;
      bnd.byte_v = in_data.data_byte;
      if (in_data.last) begin
        bnd.three = 1'b1;
        bnd.crc   = flip16(crc_nxt);
      end
    end else begin
      if (act) begin
        if (idx_r == 8'd0) len_nxt = in_data.data_byte;
        if (idx_r >= 8'd2 && idx_r < len_r) crc_nxt = crc_feed(crc_r, dly1_r);
        dly1_nxt = dly0_r;
        dly0_nxt = in_data.data_byte;
        idx_nxt  = idx_r + 8'd1;
      end
      used = (len_nxt <= idx_nxt) ? len_nxt : idx_nxt;
      if (in_data.last) begin
        bnd.vld   = 1'b1;
        bnd.lst   = 1'b1;
        bnd.crc   = flip16(crc_nxt);
        bnd.cnt   = used;
        bnd.trunc = len_nxt > idx_nxt;
      end
    end

    // frame closes: back to start-of-frame state
    if (in_data.last) begin
      crc_nxt  = '0;
      idx_nxt  = '0;
      len_nxt  = '0;
      dly0_nxt = '0;
      dly1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      idx_r  <= '0;
      len_r  <= '0;
      dly0_r <= '0;
      dly1_r <= '0;
    end else if (in_fire) begin
      crc_r  <= crc_nxt;
      idx_r  <= idx_nxt;
      len_r  <= len_nxt;
      dly0_r <= dly0_nxt;
      dly1_r <= dly1_nxt;
    end
  end

  a_idx_limit: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= Limit)
    else $error("byte index past limit");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last) |=> (idx_r == 8'd0 && crc_r == 16'd0))
    else $error("frame state not cleared after last beat");

  a_frame_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == 8'd0) |-> (crc_r == 16'd0 && len_r == 8'd0))
    else $error("stale frame state at start of frame");

endmodule

[rtl/sefcrc_out.sv]
module sefcrc_out import sefcrc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  bnd_t bnd,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  bnd_t       bnd_r;
  logic       pend_r, pend_nxt;
  logic [1:0] ph_r,   ph_nxt;
  logic       out_fire;
  logic       fin_beat;

  assign out_fire = out_valid && out_ready;
  assign fin_beat = !bnd_r.three || ph_r == 2'd2;
  assign out_valid = pend_r;
  assign in_ready  = !pend_r || (out_ready && fin_beat);

  always_comb begin
    pend_nxt = pend_r;
    ph_nxt   = ph_r;
    if (out_fire) begin
      if (fin_beat) begin
        pend_nxt = 1'b0;
        ph_nxt   = 2'd0;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
    if (in_fire && bnd.vld) begin
      pend_nxt = 1'b1;
      ph_nxt   = 2'd0;
    end
  end

  always_comb begin
    out_data.crc_value   = bnd_r.crc;
    out_data.frame_count = bnd_r.cnt;
    out_data.truncated   = bnd_r.trunc;
    case (ph_r)
      2'd0: begin
        out_data.out_byte = bnd_r.byte_v;
        out_data.out_last = bnd_r.three ? 1'b0 : bnd_r.lst;
      end
      2'd1: begin
        out_data.out_byte = bnd_r.crc[7:0];
        out_data.out_last = 1'b0;
      end
      default: begin
        out_data.out_byte = bnd_r.crc[15:8];
        out_data.out_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      ph_r   <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && bnd.vld) bnd_r <= bnd;
  end

  a_single_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !bnd_r.three) |-> ph_r == 2'd0)
    else $error("single-beat result left phase zero");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r != 2'd3)
    else $error("beat phase out of range");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> in_ready)
    else $error("empty output stage not taking input");

  a_three_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && ph_r == 2'd2 && !in_fire) |=> !pend_r)
    else $error("CRC close beat not retired");

endmodule

[rtl/secure_element_frame_crc.sv]
// Output: a result beat is registered and presented in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while the output accepts; a write-mode last beat emits three
//   output beats and holds input until the last of them is taken (output sequencer).
// Read-mode non-last beats produce no output; like any input beat they wait
//   only while an earlier result beat is still pending on the output.
// Reset: rst_n synchronous active low; clears frame state and the output stage.
module secure_element_frame_crc import sefcrc_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Byte counter saturates one below the frame capacity.
  localparam logic [7:0] Limit = 8'(MAX_FRAME - 1);

  logic in_fire;
  bnd_t bnd;

  // A beat is taken whenever the output stage has room or is retiring
  // its final pending beat in this same cycle.
  assign in_fire = in_valid && in_ready;

  // Frame state and CRC update; builds the result descriptor combinationally.
  sefcrc_core #(
    .Limit(Limit)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .bnd     (bnd)
  );

  // Result register plus beat sequencer for the appended CRC bytes.
  sefcrc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .bnd       (bnd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/tb_secure_element_frame_crc.sv]
`timescale 1ns / 100ps

module tb_secure_element_frame_crc;
  import sefcrc_pkg::*;

  localparam int FRAME_MAX = 256;
  // Frame position counter saturates here; read bytes arriving past it are dropped.
  localparam int POS_CAP = (FRAME_MAX - 1 > 255) ? 255 : FRAME_MAX - 1;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  // One queued input beat; hold_off makes the driver wait until all owed results are back.
  typedef struct {
    in_t beat;
    bit  hold_off;
  } feed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Stimulus and scoreboard storage
  feed_t byte_feed[$];
  out_t  owed_beats[$];

  // Link-model state, cleared after every closing byte
  logic [15:0] frame_crc = '0;
  logic [7:0]  frame_pos = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  held_bytes[2] = '{8'h00, 8'h00};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int owed_cnt = 0;     // result beats predicted so far
  int got_cnt = 0;      // result beats seen on the output
  int sent_cnt = 0;     // input beats accepted
  int err_cnt = 0;
  int quiet_cycles = 0;

  secure_element_frame_crc #(.MAX_FRAME(FRAME_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Link model
  // ---------------------------------------------------------------------------

  // Reflected CRC-16, poly 0xA001, one byte LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] v;
    v = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    return v;
  endfunction

  function automatic logic [15:0] bit_flip16(logic [15:0] v);
    logic [15:0] r;
    for (int k = 0; k < 16; k++)
      r[k] = v[15 - k];
    return r;
  endfunction

  function automatic void frame_clear();
    frame_crc = '0;
    frame_pos = '0;
    frame_len = '0;
    held_bytes[0] = '0;
    held_bytes[1] = '0;
  endfunction

  // Advances the link model by one accepted beat, queues the result beats it owes
  // and returns how many.
  function automatic int frame_crc_predict(in_t beat);
    out_t r;
    logic [15:0] rev;
    int made;
    made = 0;
    r = '0;
    if (beat.op == OP_WRITE) begin
      // command byte: first byte of the frame stays out of the CRC
      if (frame_pos != 8'd0)
        frame_crc = crc_byte(frame_crc, beat.data_byte);
      if (frame_pos < POS_CAP)
        frame_pos = frame_pos + 8'd1;
      r.out_byte = beat.data_byte;
      if (!beat.last) begin
        owed_beats.push_back(r);
        made = 1;
      end else begin
        // pass-through byte, then CRC low, then CRC high
        rev = bit_flip16(frame_crc);
        r.crc_value = rev;
        owed_beats.push_back(r);
        r.out_byte = rev[7:0];
        owed_beats.push_back(r);
        r.out_byte = rev[15:8];
        r.out_last = 1'b1;
        owed_beats.push_back(r);
        made = 3;
        frame_clear();
      end
    end else begin
      // response byte: CRC lags two bytes behind so the trailing CRC stays out
      if (frame_pos < POS_CAP) begin
        if (frame_pos == 8'd0)
          frame_len = beat.data_byte;
        if (frame_pos >= 8'd2 && frame_pos < frame_len)
          frame_crc = crc_byte(frame_crc, held_bytes[1]);
        held_bytes[1] = held_bytes[0];
        held_bytes[0] = beat.data_byte;
        frame_pos = frame_pos + 8'd1;
      end
      if (beat.last) begin
        r.out_last = 1'b1;
        r.crc_value = bit_flip16(frame_crc);
        r.frame_count = (frame_len <= frame_pos) ? frame_len : frame_pos;
        r.truncated = (frame_len > frame_pos);
        owed_beats.push_back(r);
        made = 1;
        frame_clear();
      end
    end
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats, random idle gaps, optional hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    int made;
    int open_beats;
    feed_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      made = 0;
      if (in_valid && in_ready) begin
        made = frame_crc_predict(in_data);
        owed_cnt <= owed_cnt + made;
        sent_cnt <= sent_cnt + 1;
      end
      // got_cnt may lag by one beat here; that only lengthens a hold-off
      open_beats = owed_cnt + made - got_cnt;
      if (!in_valid || in_ready) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(byte_feed[0].hold_off && open_beats != 0)) begin
          nxt = byte_feed.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: every output beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      got_cnt <= got_cnt + 1;
      if (owed_beats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected result beat byte=%02h last=%0b crc=%04h cnt=%0d trunc=%0b",
                   $realtime, out_data.out_byte, out_data.out_last, out_data.crc_value,
                   out_data.frame_count, out_data.truncated);
      end else begin
        want = owed_beats.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
            out_data.crc_value !== want.crc_value ||
            out_data.frame_count !== want.frame_count ||
            out_data.truncated !== want.truncated) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: mismatch exp byte=%02h last=%0b crc=%04h cnt=%0d trunc=%0b",
                     $realtime, want.out_byte, want.out_last, want.crc_value,
                     want.frame_count, want.truncated);
            $display("%0t:          got byte=%02h last=%0b crc=%04h cnt=%0d trunc=%0b",
                     $realtime, out_data.out_byte, out_data.out_last, out_data.crc_value,
                     out_data.frame_count, out_data.truncated);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("secure_element_frame_crc test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_byte(logic op, logic [7:0] b, logic lst, bit hold_off = 1'b0);
    feed_t f;
    f.beat.op = op;
    f.beat.data_byte = b;
    f.beat.last = lst;
    f.hold_off = hold_off;
    byte_feed.push_back(f);
  endtask

  // Mostly well-formed frames with random content; some broken length bytes
  // and some frames that mix both directions.
  task automatic load_random(int target, bit hold_first);
    int loaded;
    int len;
    int kind;
    logic op;
    logic [7:0] b;
    bit hold;
    loaded = 0;
    hold = hold_first;
    while (loaded < target) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        if (kind < 45) begin
          op = OP_READ;
          if (i == 0) begin
            case ($urandom_range(0, 5))
              0: b = 8'(len + $urandom_range(1, 3));   // claims more than arrives
              1: ;                                     // arbitrary length byte
              default: b = 8'(len);
            endcase
          end
        end else if (kind < 85) begin
          op = OP_WRITE;
        end else begin
          op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        end
        queue_byte(op, b, i == len - 1, hold);
        hold = 1'b0;
      end
      loaded += len;
    end
  endtask

  // Sampled at the falling edge so every always block has settled.
  task automatic drain_wait();
    @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || owed_cnt != got_cnt)
      @(negedge clk);
  endtask

  initial begin : stim
    logic op_sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: light sender gaps, heavy receiver stalls
    send_idle_pct = 10;
    recv_idle_pct = 72;

    // write frame, byte extremes; first byte stays out of the CRC
    queue_byte(OP_WRITE, 8'h00, 1'b0);
    queue_byte(OP_WRITE, 8'hFF, 1'b0);
    queue_byte(OP_WRITE, 8'h00, 1'b0);
    queue_byte(OP_WRITE, 8'hFF, 1'b1);
    // one-byte write frame: CRC is zero
    queue_byte(OP_WRITE, 8'hA5, 1'b1);
    // read, length zero
    queue_byte(OP_READ, 8'h00, 1'b1);
    // read, length one
    queue_byte(OP_READ, 8'h01, 1'b0);
    queue_byte(OP_READ, 8'hFF, 1'b1);
    // read, length two: nothing covered
    queue_byte(OP_READ, 8'h02, 1'b0);
    queue_byte(OP_READ, 8'h11, 1'b0);
    queue_byte(OP_READ, 8'h22, 1'b1);
    // read, exact length five
    queue_byte(OP_READ, 8'h05, 1'b0);
    queue_byte(OP_READ, 8'h80, 1'b0);
    queue_byte(OP_READ, 8'h7F, 1'b0);
    queue_byte(OP_READ, 8'hC3, 1'b0);
    queue_byte(OP_READ, 8'h3C, 1'b1);
    // read, max length byte but short frame: truncated
    queue_byte(OP_READ, 8'hFF, 1'b0);
    queue_byte(OP_READ, 8'h80, 1'b0);
    queue_byte(OP_READ, 8'h01, 1'b1);
    // both directions in one frame share the state
    queue_byte(OP_WRITE, 8'h10, 1'b0);
    queue_byte(OP_READ, 8'h7F, 1'b0);
    queue_byte(OP_WRITE, 8'hFF, 1'b1);
    // read, only two bytes received
    queue_byte(OP_READ, 8'h09, 1'b0);
    queue_byte(OP_READ, 8'h33, 1'b1);

    // random part opens after a full drain
    load_random(30, 1'b1);
    drain_wait();

    // phase 2: heavy sender gaps, light receiver stalls
    send_idle_pct = 72;
    recv_idle_pct = 10;
    load_random(30, 1'b0);
    drain_wait();

    // phase 3: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long frame past the position cap: reads up to the cap, two writes reaching it,
    // a dropped read, a write past the cap (still fed), and a dropped closing read
    // that still reports.
    for (int i = 0; i < 258; i++) begin
      op_sel = (i == 253 || i == 254 || i == 256) ? OP_WRITE : OP_READ;
      queue_byte(op_sel, (i == 0) ? 8'hFF : 8'($urandom_range(0, 255)), i == 257, i == 0);
    end
    load_random(15, 1'b0);
    drain_wait();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (owed_beats.size() != 0) begin
      $display("%0d owed result beats never arrived", owed_beats.size());
      err_cnt += owed_beats.size();
    end
    $display("ran %0d input beats and checked %0d result beats over write, read, mixed",
             sent_cnt, got_cnt);
    $display("and cap-saturating frames under three back-pressure mixes, %0d errors", err_cnt);
    if (err_cnt == 0)
      $display("secure_element_frame_crc test passed");
    else
      $display("secure_element_frame_crc test failed");
    $finish;
  end

endmodule
